// ===== design/gpd_pkg.sv =====
package gpd_pkg;

    localparam int PAYLOAD_SIZE = 64;
    localparam int IDX_W        = $clog2(PAYLOAD_SIZE);
    localparam int LEN_W        = $clog2(PAYLOAD_SIZE + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0]  SYNC_CODE    = 7'h10;
    localparam logic [6:0]  SIZE_CONTROL = 7'd9;
    localparam logic [6:0]  SIZE_DATA    = 7'd2;
    localparam logic [15:0] CHECK_MAGIC  = 16'haaaa;
    localparam logic [15:0] SUM_INIT     = 16'hffff;
    localparam logic [7:0]  CTRL_MARK    = 8'h80;

    localparam logic [2:0] EV_PAYLOAD  = 3'd0;
    localparam logic [2:0] EV_CONTROL  = 3'd1;
    localparam logic [2:0] EV_DATA_OK  = 3'd2;
    localparam logic [2:0] EV_HDR_ERR  = 3'd3;
    localparam logic [2:0] EV_BAD_SIZE = 3'd4;
    localparam logic [2:0] EV_CSUM_ERR = 3'd5;
    localparam logic [2:0] EV_BAD_LEN  = 3'd6;

    typedef struct packed {
        logic [2:0]       ev;
        logic [7:0]       pbyte;
        logic [IDX_W-1:0] index;
        logic [4:0]       ptype;
        logic [2:0]       arg;
        logic [2:0]       seq;
        logic [LEN_W-1:0] len;
    } res_t;

    // one queue entry: the results caused by one received byte
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== design/gpd_front.sv =====
module gpd_front
    import gpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       push,
    output entry_t     push_entry
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [2:0]       hdr_count_reg, hdr_count_next;
    logic [7:0]       hdr_xor_reg, hdr_xor_next;
    logic [6:0]       size_reg, size_next;
    logic [15:0]      check_reg, check_next;
    logic [7:0]       ctrl_reg, ctrl_next;
    logic [15:0]      target_reg, target_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [15:0]      sum_low_reg, sum_low_next;
    logic [15:0]      sum_high_reg, sum_high_next;
    logic [7:0]       prefix_reg, prefix_next;

    logic [15:0] rot;
    logic [15:0] added;
    logic [15:0] weight;
    logic [15:0] high_upd;
    logic [15:0] low_upd;
    logic        shortp;
    logic [7:0]  xor_new;
    logic [7:0]  short_len;
    res_t        res_a;
    res_t        res_b;

    // running g checksum step
    always_comb
    begin
        rot      = {sum_low_reg[14:0], sum_low_reg[15]};
        added    = rot + {8'd0, rx_byte};
        weight   = 16'(PAYLOAD_SIZE) - {{(16-IDX_W){1'b0}}, count_reg};
        high_upd = sum_high_reg + (added ^ weight);
        low_upd  = (added <= rot) ? (added ^ high_upd) : added;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        hdr_xor_next   = hdr_xor_reg;
        size_next      = size_reg;
        check_next     = check_reg;
        ctrl_next      = ctrl_reg;
        target_next    = target_reg;
        count_next     = count_reg;
        sum_low_next   = sum_low_reg;
        sum_high_next  = sum_high_reg;
        prefix_next    = prefix_reg;
        push           = 1'b0;
        res_a          = '0;
        res_b          = '0;
        push_entry     = '0;
        shortp         = ctrl_reg[6];
        xor_new        = hdr_xor_reg ^ rx_byte;
        short_len      = 8'(PAYLOAD_SIZE) - prefix_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    hdr_xor_next   = xor_new;
                    hdr_count_next = hdr_count_reg + 3'd1;
                    case (hdr_count_reg)
                        3'd0:    size_next = rx_byte[6:0];
                        3'd1:    check_next[7:0] = rx_byte;
                        3'd2:    check_next[15:8] = rx_byte;
                        3'd3:    ctrl_next = rx_byte;
                        default: ;
                    endcase
                    if (hdr_count_reg == 3'd4)
                    begin
                        phase_next     = PH_HUNT;
                        hdr_count_next = 3'd0;
                        push           = 1'b1;
                        if (xor_new != 8'd0)
                        begin
                            res_a.ev = EV_HDR_ERR;
                        end
                        else if (size_reg == SIZE_CONTROL)
                        begin
                            res_a.ev    = EV_CONTROL;
                            res_a.ptype = ctrl_reg[7:3];
                            res_a.arg   = ctrl_reg[2:0];
                        end
                        else if (size_reg == SIZE_DATA)
                        begin
                            push          = 1'b0;
                            phase_next    = PH_DATA;
                            count_next    = '0;
                            sum_low_next  = SUM_INIT;
                            sum_high_next = 16'd0;
                            prefix_next   = 8'd0;
                            // final sum must equal this for a good packet
                            target_next   = (CHECK_MAGIC - check_reg)
                                            ^ {8'd0, ctrl_reg | CTRL_MARK};
                        end
                        else
                        begin
                            res_a.ev = EV_BAD_SIZE;
                        end
                    end
                end
                PH_DATA:
                begin
                    sum_low_next  = low_upd;
                    sum_high_next = high_upd;
                    count_next    = count_reg + 1'b1;
                    if (count_reg == '0)
                    begin
                        prefix_next = rx_byte;
                    end
                    res_a.ev    = EV_PAYLOAD;
                    res_a.pbyte = rx_byte;
                    res_a.index = shortp ? (count_reg - 1'b1) : count_reg;
                    push        = !(shortp && count_reg == '0);
                    if (count_reg == IDX_W'(PAYLOAD_SIZE - 1))
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        res_b.arg  = ctrl_reg[2:0];
                        res_b.seq  = ctrl_reg[5:3];
                        if (low_upd != target_reg)
                        begin
                            res_b.ev = EV_CSUM_ERR;
                        end
                        else if (shortp && prefix_reg > 8'(PAYLOAD_SIZE))
                        begin
                            res_b.ev = EV_BAD_LEN;
                        end
                        else
                        begin
                            res_b.ev  = EV_DATA_OK;
                            res_b.len = shortp ? LEN_W'(short_len)
                                               : LEN_W'(PAYLOAD_SIZE);
                        end
                        push_entry.two = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte[6:0] == SYNC_CODE)
                    begin
                        phase_next     = PH_HDR;
                        hdr_count_next = 3'd0;
                        hdr_xor_next   = 8'd0;
                    end
                end
            endcase
        end
        push_entry.r0 = res_a;
        push_entry.r1 = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            hdr_count_reg <= 3'd0;
            hdr_xor_reg   <= 8'd0;
            size_reg      <= 7'd0;
            check_reg     <= 16'd0;
            ctrl_reg      <= 8'd0;
            target_reg    <= 16'd0;
            count_reg     <= '0;
            sum_low_reg   <= SUM_INIT;
            sum_high_reg  <= 16'd0;
            prefix_reg    <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            hdr_xor_reg   <= hdr_xor_next;
            size_reg      <= size_next;
            check_reg     <= check_next;
            ctrl_reg      <= ctrl_next;
            target_reg    <= target_next;
            count_reg     <= count_next;
            sum_low_reg   <= sum_low_next;
            sum_high_reg  <= sum_high_next;
            prefix_reg    <= prefix_next;
        end
    end

endmodule

// ===== design/gpd_queue.sv =====
module gpd_queue
    import gpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t stat
);

    entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/gpd_back.sv =====
module gpd_back
    import gpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  entry_t  head,
    input  q_stat_t stat,
    output logic    pop,
    input  logic    res_stall,
    output logic    res_valid,
    output res_t    res,
    output logic    res_last
);

    logic out_valid_reg;
    res_t out_res_reg;
    logic out_last_reg;
    logic hold_valid_reg;
    res_t hold_res_reg;
    logic advance;

    assign advance   = !out_valid_reg || !res_stall;
    assign pop       = advance && !hold_valid_reg && !stat.empty;
    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;
    assign res_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_res_reg    <= '0;
            out_last_reg   <= 1'b0;
            hold_res_reg   <= '0;
        end
        else if (advance)
        begin
            if (hold_valid_reg)
            begin
                // second result of the same item
                out_valid_reg  <= 1'b1;
                out_res_reg    <= hold_res_reg;
                out_last_reg   <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else if (!stat.empty)
            begin
                out_valid_reg  <= 1'b1;
                out_res_reg    <= head.r0;
                out_last_reg   <= !head.two;
                hold_valid_reg <= head.two;
                hold_res_reg   <= head.r1;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/g_protocol_packet_deframer_top.sv =====
// g-protocol receive deframer: takes one serial byte per item on the rx channel,
// hunts for the sync byte, checks the five-byte header and then streams out the
// payload bytes of a data packet (short-packet prefix dropped) followed by a
// verdict, or reports a control packet, a header error or an unsupported size.
// a new byte is taken every cycle; the front end classifies it and updates the
// 16-bit running checksum in that same cycle, so rx_stall rises only when the
// four-entry queue to the output side is full. results leave one per cycle, while
// res_stall is low, from the output register, so the byte that closes a data
// packet, which yields both its payload byte and the verdict, sends two results
// through the output register; the queue soaks that up, and with no stall a full
// 64-byte data packet still passes at one byte a cycle. the first result of a
// byte is written into the queue and then moves into the output register.
// last marks the final result caused by one input byte.
module g_protocol_packet_deframer_top
    import gpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rx_valid,
    output logic             rx_stall,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [2:0]       event_res,
    output logic [7:0]       payload_byte,
    output logic [IDX_W-1:0] byte_index,
    output logic [4:0]       packet_type,
    output logic [2:0]       argument,
    output logic [2:0]       seq_number,
    output logic [LEN_W-1:0] length,
    output logic             last
);

    logic    accept;
    logic    push;
    entry_t  push_entry;
    logic    pop;
    entry_t  head;
    q_stat_t q_stat;
    res_t    res;

    // front end is stalled only by a full queue
    assign rx_stall = q_stat.full;
    assign accept   = rx_valid && !rx_stall;

    gpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    // per-byte result entries between the classifier and the output side
    gpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    gpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (q_stat),
        .pop       (pop),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res),
        .res_last  (last)
    );

    assign event_res    = res.ev;
    assign payload_byte = res.pbyte;
    assign byte_index   = res.index;
    assign packet_type  = res.ptype;
    assign argument     = res.arg;
    assign seq_number   = res.seq;
    assign length       = res.len;

    // every verdict or report closes the results of its byte
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res != EV_PAYLOAD |-> last)
        else $error("verdict without last");

    // payload value only travels with a payload event
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'd0)
        else $error("payload byte on non-payload event");

    // queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("queue overflow");

    // a pop only happens on a non-empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue underflow");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

// testbench for the g-protocol receive deframer
// bytes go in on the rx channel as framed packets, noise and broken frames;
// a byte-level model of the receiver, kept here, predicts the results each
// accepted item causes and the checker matches every result against the
// oldest prediction, field by field
module tb;
    import gpd_pkg::*;

    // run shape
    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 770;
    localparam int DRAIN_CYCLES = 8;

    // control byte flag that marks a short packet (first payload byte is a prefix count)
    localparam logic [7:0] SHORT_FLAG = 8'h40;

    typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_PAYLOAD} rx_phase_e;
    typedef enum int {CLEAN, BAD_CHECK, BAD_XOR} fault_e;

    typedef struct {
        logic [2:0]       ev;
        logic [7:0]       pbyte;
        logic [IDX_W-1:0] index;
        logic [4:0]       ptype;
        logic [2:0]       arg;
        logic [2:0]       seq;
        logic [LEN_W-1:0] len;
        logic             last;
    } frame_result_t;

    // clock, reset and dut inputs, all known from time zero
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic rx_valid  = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic res_stall = 1'b0;

    logic             rx_stall;
    logic             res_valid;
    logic [2:0]       event_res;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic [4:0]       packet_type;
    logic [2:0]       argument;
    logic [2:0]       seq_number;
    logic [LEN_W-1:0] length;
    logic             last;

    // receiver model state, starts at its reset values
    rx_phase_e   phase      = HUNTING;
    logic [2:0]  hdr_count  = '0;
    logic [7:0]  hdr_xor    = '0;
    logic [7:0]  size_code  = '0;
    logic [15:0] check_word = '0;
    logic [7:0]  ctrl       = '0;
    logic [6:0]  data_count = '0;
    logic [15:0] sum_lo     = SUM_INIT;
    logic [15:0] sum_hi     = '0;
    logic [7:0]  prefix     = '0;

    // results predicted but not yet seen, oldest first
    frame_result_t due_results[$];
    frame_result_t want_res;

    int  rx_items     = 0;
    int  noise_items  = 0;
    int  errors       = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    int  stall_left   = 0;
    bit  idle_on      = 1'b0;
    bit  stall_on     = 1'b0;

    g_protocol_packet_deframer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .event_res    (event_res),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .packet_type  (packet_type),
        .argument     (argument),
        .seq_number   (seq_number),
        .length       (length),
        .last         (last)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // checksum arithmetic, shared by the receiver model and the packet builder
    // ---------------------------------------------------------------

    // one byte of the running g checksum: rotate, add, fold into the high sum
    function automatic void cksum_step(inout logic [15:0] lo, inout logic [15:0] hi,
                                       input logic [7:0] b, input logic [15:0] weight);
        logic [15:0] prev;
        lo   = {lo[14:0], lo[15]};
        prev = lo;
        lo   = lo + {8'h00, b};
        hi   = hi + (lo ^ weight);
        // carry out of the add (or no change) mixes the high sum back in
        if (lo <= prev)
            lo = lo ^ hi;
    endfunction

    // header check word that a packet with this low sum and control byte must carry
    function automatic logic [15:0] check_value(input logic [15:0] lo, input logic [7:0] c);
        return CHECK_MAGIC - (lo ^ {8'h00, c | CTRL_MARK});
    endfunction

    // ---------------------------------------------------------------
    // receiver model
    // ---------------------------------------------------------------

    function automatic void push_result(input logic [2:0] ev, input logic [7:0] pbyte,
                                        input logic [IDX_W-1:0] index, input logic [4:0] ptype,
                                        input logic [2:0] arg, input logic [2:0] seq,
                                        input logic [LEN_W-1:0] len, input logic lst);
        frame_result_t r;
        r.ev    = ev;
        r.pbyte = pbyte;
        r.index = index;
        r.ptype = ptype;
        r.arg   = arg;
        r.seq   = seq;
        r.len   = len;
        r.last  = lst;
        due_results.push_back(r);
    endfunction

    // advance the receiver by one accepted byte and queue the results it causes
    task automatic deframe_byte(input logic [7:0] b);
        logic [6:0]  pos;
        logic        shortp;
        logic [15:0] calc;
        case (phase)
            IN_HEADER:
            begin
                hdr_xor = hdr_xor ^ b;
                case (hdr_count)
                    3'd0: size_code = b;
                    3'd1: check_word[7:0] = b;
                    3'd2: check_word[15:8] = b;
                    3'd3: ctrl = b;
                    default: ;
                endcase
                hdr_count = hdr_count + 3'd1;
                if (hdr_count == 3'd5)
                begin
                    phase     = HUNTING;
                    hdr_count = '0;
                    if (hdr_xor != 8'h00)
                        push_result(EV_HDR_ERR, 0, 0, 0, 0, 0, 0, 1'b1);
                    else if (size_code[6:0] == SIZE_CONTROL)
                        push_result(EV_CONTROL, 0, 0, ctrl[7:3], ctrl[2:0], 0, 0, 1'b1);
                    else if (size_code[6:0] == SIZE_DATA)
                    begin
                        phase      = IN_PAYLOAD;
                        data_count = '0;
                        sum_lo     = SUM_INIT;
                        sum_hi     = '0;
                        prefix     = '0;
                    end
                    else
                        push_result(EV_BAD_SIZE, 0, 0, 0, 0, 0, 0, 1'b1);
                end
            end
            IN_PAYLOAD:
            begin
                pos    = data_count;
                shortp = (ctrl & SHORT_FLAG) != 8'h00;
                cksum_step(sum_lo, sum_hi, b, 16'(PAYLOAD_SIZE) - 16'(pos));
                if (pos == 7'd0)
                    prefix = b;
                data_count = data_count + 7'd1;
                // a short packet swallows its prefix byte, later bytes shift down by one;
                // the closing byte's payload result is never the last one
                if (!shortp)
                    push_result(EV_PAYLOAD, b, IDX_W'(pos), 0, 0, 0, 0,
                                data_count < 7'(PAYLOAD_SIZE));
                else if (pos != 7'd0)
                    push_result(EV_PAYLOAD, b, IDX_W'(pos - 7'd1), 0, 0, 0, 0,
                                data_count < 7'(PAYLOAD_SIZE));
                if (data_count >= 7'(PAYLOAD_SIZE))
                begin
                    phase      = HUNTING;
                    data_count = '0;
                    calc       = check_value(sum_lo, ctrl);
                    // checksum beats bad length beats good
                    if (calc != check_word)
                        push_result(EV_CSUM_ERR, 0, 0, 0, ctrl[2:0], ctrl[5:3], 0, 1'b1);
                    else if (shortp && prefix > 8'(PAYLOAD_SIZE))
                        push_result(EV_BAD_LEN, 0, 0, 0, ctrl[2:0], ctrl[5:3], 0, 1'b1);
                    else
                        push_result(EV_DATA_OK, 0, 0, 0, ctrl[2:0], ctrl[5:3],
                                    LEN_W'(PAYLOAD_SIZE - (shortp ? int'(prefix) : 0)), 1'b1);
                end
            end
            default:
            begin
                // hunting: sync byte ignores bit 7
                phase = HUNTING;
                if (b[6:0] == SYNC_CODE)
                begin
                    phase     = IN_HEADER;
                    hdr_count = '0;
                    hdr_xor   = '0;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // idling on both sides
    // ---------------------------------------------------------------

    // mostly short spans, now and then a long one
    function automatic int random_span();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_gap();
        if (!idle_on || $urandom_range(0, 99) < 60)
            return 0;
        return random_span();
    endfunction

    // result side stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_stall  <= 1'b1;
        end
        else if (stall_on && $urandom_range(0, 99) < 30)
        begin
            stall_left <= random_span() - 1;
            res_stall  <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // offer one item, hold it until taken, then feed it to the model
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        deframe_byte(b);
        rx_items++;
    endtask

    // sync byte plus the five header bytes, xor byte optionally spoiled
    task automatic send_frame(input logic [7:0] size_b, input logic [15:0] chk,
                              input logic [7:0] c, input logic spoil_xor);
        logic [7:0] x;
        x = size_b ^ chk[7:0] ^ chk[15:8] ^ c;
        if (spoil_xor)
            x = x ^ 8'($urandom_range(1, 255));
        send_byte({1'($urandom), SYNC_CODE});
        send_byte(size_b);
        send_byte(chk[7:0]);
        send_byte(chk[15:8]);
        send_byte(c);
        send_byte(x);
    endtask

    // data packet with random payload; lead is the prefix count of a short packet
    task automatic send_data_packet(input logic [7:0] c, input logic [7:0] lead,
                                    input fault_e fault);
        logic [7:0]  body [PAYLOAD_SIZE];
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] chk;
        lo = SUM_INIT;
        hi = '0;
        for (int i = 0; i < PAYLOAD_SIZE; i++)
        begin
            body[i] = (i == 0 && (c & SHORT_FLAG) != 8'h00) ? lead : 8'($urandom);
            cksum_step(lo, hi, body[i], 16'(PAYLOAD_SIZE - i));
        end
        chk = check_value(lo, c);
        if (fault == BAD_CHECK)
            chk = chk ^ (16'h0001 << $urandom_range(0, 15));
        send_frame({1'($urandom), SIZE_DATA}, chk, c, fault == BAD_XOR);
        for (int i = 0; i < PAYLOAD_SIZE; i++)
            send_byte(body[i]);
    endtask

    task automatic send_control(input logic [7:0] c);
        send_frame({1'($urandom), SIZE_CONTROL}, 16'($urandom), c, 1'b0);
    endtask

    function automatic logic [6:0] odd_size();
        logic [6:0] s;
        do
            s = 7'($urandom);
        while (s == SIZE_DATA || s == SIZE_CONTROL);
        return s;
    endfunction

    // line noise, counted apart so it does not pad the item budget
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_byte(8'($urandom));
            noise_items++;
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // control packets at the extremes of the control byte and one in between, behind a little noise
    task automatic test_control();
        idle_on = 1'b0;
        stall_on <= 1'b0;
        send_byte(8'h11);
        send_byte(8'h00);
        send_control(8'h00);
        send_control(8'hff);
        send_control(8'h5a);
    endtask

    // spoiled header xor and unsupported size codes, with bit 7 both ways
    task automatic test_header_faults();
        idle_on = 1'b1;
        stall_on <= 1'b1;
        send_frame({1'b0, SIZE_CONTROL}, 16'h1234, 8'h3c, 1'b1);
        send_frame(8'h00, 16'h0000, 8'h00, 1'b0);
        send_frame(8'hff, 16'hffff, 8'hff, 1'b0);
        send_frame({1'b1, 7'h0a}, 16'h8001, 8'h81, 1'b0);
    endtask

    // full-length data packets: good with both extreme control bytes, then a bad checksum
    task automatic test_long_data();
        idle_on = 1'b0;
        stall_on <= 1'b1;
        send_data_packet(8'h00, 8'h00, CLEAN);
        send_data_packet(8'hbf, 8'h00, CLEAN);
        send_data_packet(8'h2d, 8'h00, BAD_CHECK);
    endtask

    // short packets: prefix at zero, at the payload size, just above it, at the top, a checksum
    // error that must win over a bad length, and one with a spoiled header xor
    task automatic test_short_data();
        idle_on = 1'b1;
        stall_on <= 1'b0;
        send_data_packet(8'h40, 8'h00, CLEAN);
        send_data_packet(8'h7f, 8'(PAYLOAD_SIZE), CLEAN);
        send_data_packet(8'hc5, 8'(PAYLOAD_SIZE + 1), CLEAN);
        send_data_packet(8'hff, 8'hff, CLEAN);
        send_data_packet(8'h53, 8'd100, BAD_CHECK);
        send_data_packet(8'h61, 8'd17, BAD_XOR);
    endtask

    // mostly well-formed packets with random content, some broken ones and noise,
    // idling switched on and off in stretches
    task automatic test_random();
        int         start;
        int         pick;
        logic [7:0] c;
        logic [7:0] lead;
        fault_e     fault;
        start = rx_items - noise_items;
        while (rx_items - noise_items - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                idle_on = $urandom_range(0, 3) != 0;
                stall_on <= $urandom_range(0, 3) != 0;
            end
            pick  = $urandom_range(0, 99);
            c     = 8'($urandom);
            lead  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(PAYLOAD_SIZE + 1, 255))
                                               : 8'($urandom_range(0, PAYLOAD_SIZE));
            fault = ($urandom_range(0, 7) == 0) ? BAD_CHECK : CLEAN;
            if (pick < 45)
                send_data_packet(c, lead, fault);
            else if (pick < 70)
                send_control(c);
            else if (pick < 80)
                send_frame({1'($urandom), odd_size()}, 16'($urandom), c, 1'b0);
            else if (pick < 85)
                send_frame({1'($urandom), SIZE_CONTROL}, 16'($urandom), c, 1'b1);
            else if (pick < 90)
                send_data_packet(c, lead, BAD_XOR);
            else
                send_noise($urandom_range(1, 6));
        end
    endtask

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_error(input string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_seen, name, got, want));
    endtask

    // every accepted result is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_results.size() == 0)
                report_error($sformatf("result %0d: event %0d arrived with nothing due",
                                       results_seen, event_res));
            else
            begin
                want_res = due_results.pop_front();
                check_field("event_res", 8'(event_res), 8'(want_res.ev));
                check_field("payload_byte", payload_byte, want_res.pbyte);
                check_field("byte_index", 8'(byte_index), 8'(want_res.index));
                check_field("packet_type", 8'(packet_type), 8'(want_res.ptype));
                check_field("argument", 8'(argument), 8'(want_res.arg));
                check_field("seq_number", 8'(seq_number), 8'(want_res.seq));
                check_field("length", 8'(length), 8'(want_res.len));
                check_field("last", 8'(last), 8'(want_res.last));
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("g_protocol_packet_deframer_top: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_control();
        test_header_faults();
        test_long_data();
        test_short_data();
        test_random();

        // drain: everything predicted must arrive, then a few quiet cycles
        rx_valid <= 1'b0;
        stall_on <= 1'b1;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("g_protocol_packet_deframer_top: match");
        else
            $display("g_protocol_packet_deframer_top: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/gpd_pkg.sv
design/gpd_front.sv
design/gpd_queue.sv
design/gpd_back.sv
design/g_protocol_packet_deframer_top.sv
sim/tb.sv
